FILE: rtl/lcc_pkg.sv
// Shared types and constants for the line crossing counter.
// Controller commands, datapath status, state encoding and register indexes.
// No dependencies.
`default_nettype none

package lcc_pkg;

  // Widths set by the fixed interface
  localparam int LINE_IDX_W  = 2;   // up to four counting lines
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int ID_W        = 8;
  localparam int POS_W       = 16;
  localparam int LUSE_W      = 3;
  localparam int CNT_W       = 32;

  // Parameter defaults
  localparam int DEF_MAX_TRACKS = 256;
  localparam int DEF_MAX_LINES  = 4;
  localparam int DEF_COORD_BITS = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LINE_ZERO    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_THREE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINES_IN_USE = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINES,
    ST_FLUSH,
    ST_TOT
  } lcc_state_t;

  typedef struct packed {
    logic                  start;       // capture item, read side table
    logic                  mul_en;      // form cross product terms
    logic [LINE_IDX_W-1:0] line;        // line for mul_en
    logic                  load_entry;  // take side table word into entry
    logic                  wr_en;       // write entry back
    logic                  out_load;    // load result register
  } lcc_cmd_t;

  typedef struct packed {
    logic                  proc;        // item updates state
    logic [LINE_IDX_W-1:0] last_line;   // index of last active line
    logic                  slot_free;   // result register can take a value
  } lcc_stat_t;

endpackage

`default_nettype wire

FILE: rtl/line_crossing_counter_core.sv
// Line crossing counter: top level, joins lcc_ctrl and lcc_datapath.
// Flow: capture, then the n active lines one a cycle through one shared cross product
//   unit, side word write-back and result load; an ignored update (no history, id out of
//   range, n zero) skips the cross products and the write-back. A new item is taken only
//   after the previous one has loaded its result; a stalled earlier result holds that load.
// Reset (rst_n low, synchronous): counters, line registers, line count and side flags cleared.
`default_nettype none

module line_crossing_counter_core #(
  parameter int MAX_TRACKS = lcc_pkg::DEF_MAX_TRACKS,  // side table depth (max 256 used)
  parameter int MAX_LINES  = lcc_pkg::DEF_MAX_LINES,   // 1..4 counting lines
  parameter int COORD_BITS = lcc_pkg::DEF_COORD_BITS   // coordinate bits used, 8..16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lcc_pkg::CFG_DATA_W-1:0] cfg_data,
  // track updates
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [lcc_pkg::ID_W-1:0]       in_track_id,
  input  wire logic [lcc_pkg::POS_W-1:0]      in_pos_x,
  input  wire logic [lcc_pkg::POS_W-1:0]      in_pos_y,
  input  wire logic                           in_has_history,
  // results
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [lcc_pkg::CNT_W-1:0]           out_total_in,
  output logic [lcc_pkg::CNT_W-1:0]           out_total_out,
  output logic signed [lcc_pkg::CNT_W:0]      out_net_count,
  output logic [3:0]                          out_crossed_in_mask,
  output logic [3:0]                          out_crossed_out_mask
);

  lcc_pkg::lcc_cmd_t  cmd;
  lcc_pkg::lcc_stat_t stat;

  // Register writes take effect at the transfer edge; the port never back-pressures.
  assign cfg_ready = 1'b1;

  // Sequencer: accepts a transfer only when idle, then steps through the
  // active lines, writes the side word back and hands the result over.
  lcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: cross product of one line a cycle into registered products, then compared;
  // side table, per-line saturating counters and the result register,
  // which lets the next transfer in while a result waits.
  lcc_datapath #(
    .MAX_TRACKS (MAX_TRACKS),
    .MAX_LINES  (MAX_LINES),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_track_id          (in_track_id),
    .in_pos_x             (in_pos_x),
    .in_pos_y             (in_pos_y),
    .in_has_history       (in_has_history),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_total_in         (out_total_in),
    .out_total_out        (out_total_out),
    .out_net_count        (out_net_count),
    .out_crossed_in_mask  (out_crossed_in_mask),
    .out_crossed_out_mask (out_crossed_out_mask)
  );

endmodule

`default_nettype wire

FILE: rtl/lcc_ctrl.sv
// Sequencer for the line crossing counter.
// Walks the active lines, then write-back and result hand-off. Uses lcc_pkg.
`default_nettype none

module lcc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire lcc_pkg::lcc_stat_t stat,
  output lcc_pkg::lcc_cmd_t      cmd
);

  lcc_pkg::lcc_state_t state_r, state_nxt;
  logic [lcc_pkg::LINE_IDX_W-1:0] k_r, k_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcc_pkg::ST_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    case (state_r)
      lcc_pkg::ST_IDLE: begin
        k_nxt = '0;
        if (in_valid) begin
          state_nxt = lcc_pkg::ST_LINES;
        end
      end
      lcc_pkg::ST_LINES: begin
        if (!stat.proc) begin
          state_nxt = lcc_pkg::ST_TOT;
        end else if (k_r == stat.last_line) begin
          state_nxt = lcc_pkg::ST_FLUSH;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      lcc_pkg::ST_FLUSH: begin
        state_nxt = lcc_pkg::ST_TOT;
      end
      lcc_pkg::ST_TOT: begin
        if (stat.slot_free) begin
          state_nxt = lcc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lcc_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.line = k_r;
    in_stall = 1'b1;
    case (state_r)
      lcc_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.start = in_valid;
      end
      lcc_pkg::ST_LINES: begin
        cmd.mul_en     = stat.proc;
        cmd.load_entry = (k_r == '0);
      end
      lcc_pkg::ST_FLUSH: begin
        cmd.wr_en = 1'b1;
      end
      lcc_pkg::ST_TOT: begin
        cmd.out_load = stat.slot_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/lcc_datapath.sv
// Datapath: line registers, side table, cross product unit, counters, result register.
// Driven by lcc_ctrl commands. Uses lcc_pkg.
`default_nettype none

module lcc_datapath #(
  parameter int MAX_TRACKS = lcc_pkg::DEF_MAX_TRACKS,
  parameter int MAX_LINES  = lcc_pkg::DEF_MAX_LINES,
  parameter int COORD_BITS = lcc_pkg::DEF_COORD_BITS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_valid,
  input  wire logic [lcc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [lcc_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic [lcc_pkg::ID_W-1:0]              in_track_id,
  input  wire logic [lcc_pkg::POS_W-1:0]             in_pos_x,
  input  wire logic [lcc_pkg::POS_W-1:0]             in_pos_y,
  input  wire logic                                  in_has_history,
  input  wire lcc_pkg::lcc_cmd_t                     cmd,
  output lcc_pkg::lcc_stat_t                         stat,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [lcc_pkg::CNT_W-1:0]                  out_total_in,
  output logic [lcc_pkg::CNT_W-1:0]                  out_total_out,
  output logic signed [lcc_pkg::CNT_W:0]             out_net_count,
  output logic [3:0]                                 out_crossed_in_mask,
  output logic [3:0]                                 out_crossed_out_mask
);

  localparam int TBL_DEPTH = (MAX_TRACKS > 256) ? 256 : MAX_TRACKS;
  localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int LIW       = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CB        = COORD_BITS;
  localparam int PW        = 2 * CB + 2;
  localparam int CW        = lcc_pkg::CNT_W;

  // configuration
  logic [CB-1:0] x1_r [MAX_LINES];
  logic [CB-1:0] y1_r [MAX_LINES];
  logic [CB-1:0] x2_r [MAX_LINES];
  logic [CB-1:0] y2_r [MAX_LINES];
  logic [lcc_pkg::LUSE_W-1:0] luse_r;
  logic [lcc_pkg::LUSE_W-1:0] lines_act;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < MAX_LINES; l++) begin
        x1_r[l] <= '0;
        y1_r[l] <= '0;
        x2_r[l] <= '0;
        y2_r[l] <= '0;
      end
    end else if (cfg_valid && cfg_index <= lcc_pkg::REG_LINE_THREE &&
        cfg_index < lcc_pkg::CFG_IDX_W'(MAX_LINES)) begin
      x1_r[cfg_index[LIW-1:0]] <= cfg_data[0  +: CB];
      y1_r[cfg_index[LIW-1:0]] <= cfg_data[16 +: CB];
      x2_r[cfg_index[LIW-1:0]] <= cfg_data[32 +: CB];
      y2_r[cfg_index[LIW-1:0]] <= cfg_data[48 +: CB];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      luse_r <= '0;
    end else if (cfg_valid && cfg_index == lcc_pkg::REG_LINES_IN_USE) begin
      luse_r <= cfg_data[lcc_pkg::LUSE_W-1:0];
    end
  end

  assign lines_act = (luse_r > lcc_pkg::LUSE_W'(MAX_LINES)) ?
                     lcc_pkg::LUSE_W'(MAX_LINES) : luse_r;

  // captured item
  logic [lcc_pkg::ID_W-1:0] id_r;
  logic [CB-1:0]            px_r, py_r;
  logic                     hist_r, id_ok_r;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      id_r    <= in_track_id;
      px_r    <= in_pos_x[CB-1:0];
      py_r    <= in_pos_y[CB-1:0];
      hist_r  <= in_has_history;
      id_ok_r <= (32'(in_track_id) < 32'(MAX_TRACKS));
    end
  end

  // side table: word is {left, seen}, per-entry valid flags cleared by reset
  logic [2*MAX_LINES-1:0] side_mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0]   tvld_r;
  logic [2*MAX_LINES-1:0] rd_word_r;
  logic                   rd_vld_r;
  logic [MAX_LINES-1:0]   seen_r, seen_nxt, left_r, left_nxt;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      side_mem[id_r[TBL_AW-1:0]] <= {left_nxt, seen_nxt};
    end
    if (cmd.start) begin
      rd_word_r <= side_mem[in_track_id[TBL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tvld_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        tvld_r[id_r[TBL_AW-1:0]] <= 1'b1;
      end
      if (cmd.start) begin
        rd_vld_r <= tvld_r[in_track_id[TBL_AW-1:0]];
      end
    end
  end

  // cross product terms, one line a cycle
  logic signed [CB:0]   dx, dy, ex, ey;
  logic signed [PW-1:0] pa_r, pb_r;
  logic signed [PW:0]   cp;
  logic                 cmp_en_r, curr;
  logic [LIW-1:0]       ml, cl_r;

  assign ml = cmd.line[LIW-1:0];

  always_comb begin
    dx = $signed({1'b0, x2_r[ml]}) - $signed({1'b0, x1_r[ml]});
    dy = $signed({1'b0, y2_r[ml]}) - $signed({1'b0, y1_r[ml]});
    ex = $signed({1'b0, px_r}) - $signed({1'b0, x1_r[ml]});
    ey = $signed({1'b0, py_r}) - $signed({1'b0, y1_r[ml]});
  end

  always_ff @(posedge clk) begin
    pa_r <= dx * ey;
    pb_r <= dy * ex;
    cl_r <= ml;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_en_r <= 1'b0;
    end else begin
      cmp_en_r <= cmd.mul_en;
    end
  end

  assign cp   = $signed({pa_r[PW-1], pa_r}) - $signed({pb_r[PW-1], pb_r});
  assign curr = !cp[PW] && (cp != '0);

  // side update, counters, masks
  logic [CW-1:0]        in_cnt_r [MAX_LINES];
  logic [CW-1:0]        out_cnt_r[MAX_LINES];
  logic [CW-1:0]        in_cnt_nxt [MAX_LINES];
  logic [CW-1:0]        out_cnt_nxt[MAX_LINES];
  logic [MAX_LINES-1:0] imask_r, imask_nxt, omask_r, omask_nxt;

  always_comb begin
    seen_nxt    = seen_r;
    left_nxt    = left_r;
    in_cnt_nxt  = in_cnt_r;
    out_cnt_nxt = out_cnt_r;
    imask_nxt   = imask_r;
    omask_nxt   = omask_r;
    if (cmd.start) begin
      imask_nxt = '0;
      omask_nxt = '0;
    end
    if (cmd.load_entry) begin
      seen_nxt = rd_vld_r ? rd_word_r[MAX_LINES-1:0] : '0;
      left_nxt = rd_vld_r ? rd_word_r[2*MAX_LINES-1:MAX_LINES] : '0;
    end
    if (cmp_en_r) begin
      if (seen_r[cl_r]) begin
        if (left_r[cl_r] && !curr) begin
          if (out_cnt_r[cl_r] != '1) begin
            out_cnt_nxt[cl_r] = out_cnt_r[cl_r] + 1'b1;
          end
          omask_nxt[cl_r] = 1'b1;
        end else if (!left_r[cl_r] && curr) begin
          if (in_cnt_r[cl_r] != '1) begin
            in_cnt_nxt[cl_r] = in_cnt_r[cl_r] + 1'b1;
          end
          imask_nxt[cl_r] = 1'b1;
        end
      end
      seen_nxt[cl_r] = 1'b1;
      left_nxt[cl_r] = curr;
    end
  end

  always_ff @(posedge clk) begin
    seen_r  <= seen_nxt;
    left_r  <= left_nxt;
    imask_r <= imask_nxt;
    omask_r <= omask_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < MAX_LINES; l++) begin
        in_cnt_r[l]  <= '0;
        out_cnt_r[l] <= '0;
      end
    end else begin
      in_cnt_r  <= in_cnt_nxt;
      out_cnt_r <= out_cnt_nxt;
    end
  end

  // totals over active lines, saturating
  logic [CW+1:0] tin_sum, tout_sum;
  logic [CW-1:0] tin, tout;

  always_comb begin
    tin_sum  = '0;
    tout_sum = '0;
    for (int l = 0; l < MAX_LINES; l++) begin
      if (lcc_pkg::LUSE_W'(l) < lines_act) begin
        tin_sum  = tin_sum  + (CW+2)'(in_cnt_r[l]);
        tout_sum = tout_sum + (CW+2)'(out_cnt_r[l]);
      end
    end
    tin  = (tin_sum[CW+1:CW]  != 2'b00) ? '1 : tin_sum[CW-1:0];
    tout = (tout_sum[CW+1:CW] != 2'b00) ? '1 : tout_sum[CW-1:0];
  end

  // result register
  logic          out_valid_r;
  logic [CW-1:0] tin_r, tout_r;
  logic [CW:0]   net_r;
  logic [3:0]    oim_r, oom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      tin_r  <= tin;
      tout_r <= tout;
      net_r  <= {1'b0, tin} - {1'b0, tout};
      oim_r  <= 4'(imask_r);
      oom_r  <= 4'(omask_r);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_total_in         = tin_r;
  assign out_total_out        = tout_r;
  assign out_net_count        = $signed(net_r);
  assign out_crossed_in_mask  = oim_r;
  assign out_crossed_out_mask = oom_r;

  assign stat.proc      = hist_r && id_ok_r && (lines_act != '0);
  assign stat.last_line = lcc_pkg::LINE_IDX_W'(lines_act - 1'b1);
  assign stat.slot_free = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

FILE: tb/lcc_crossing_checker.sv
`timescale 1ns / 100ps
// Scoreboard for line_crossing_counter_core: mirrors register writes, works out the
// expected totals and crossing masks per accepted track update, compares results.
// Depends on lcc_pkg.

module lcc_crossing_checker
  import lcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [ID_W-1:0]       in_track_id,
  input  logic [POS_W-1:0]      in_pos_x,
  input  logic [POS_W-1:0]      in_pos_y,
  input  logic                  in_has_history,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [CNT_W-1:0]      out_total_in,
  input  logic [CNT_W-1:0]      out_total_out,
  input  logic signed [CNT_W:0] out_net_count,
  input  logic [3:0]            out_crossed_in_mask,
  input  logic [3:0]            out_crossed_out_mask,
  output int                    mismatch_count,
  output int                    pending_results
);

  localparam int TRACKS = DEF_MAX_TRACKS;
  localparam int LINES  = DEF_MAX_LINES;
  localparam logic [CNT_W-1:0] CNT_FULL = '1;

  typedef struct packed {
    logic [CNT_W-1:0] total_in;
    logic [CNT_W-1:0] total_out;
    logic [CNT_W:0]   net;
    logic [3:0]       in_mask;
    logic [3:0]       out_mask;
  } tally_t;

  logic [CFG_DATA_W-1:0] line_reg [4];
  logic [LUSE_W-1:0]     lines_used;
  logic [7:0]            side_map [TRACKS];  // per line: bit 2l seen, bit 2l+1 left
  logic [CNT_W-1:0]      in_cnt [4];
  logic [CNT_W-1:0]      out_cnt [4];
  tally_t                expected_tallies [$];

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  // strictly positive cross product only; on the line counts as right
  function automatic bit left_of(input logic [CFG_DATA_W-1:0] seg,
                                 input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
    longint x1, y1, x2, y2;
    x1 = longint'(seg[15:0]);
    y1 = longint'(seg[31:16]);
    x2 = longint'(seg[47:32]);
    y2 = longint'(seg[63:48]);
    return ((x2 - x1) * (longint'(py) - y1) - (y2 - y1) * (longint'(px) - x1)) > 0;
  endfunction

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v == CNT_FULL) ? v : v + 1'b1;
  endfunction

  // updates side table and counters, returns the result the update should give
  function automatic tally_t tally_update(input logic [ID_W-1:0] id,
                                          input logic [POS_W-1:0] px,
                                          input logic [POS_W-1:0] py, input logic hist);
    tally_t         t;
    int             n;
    logic [7:0]     entry;
    logic           was_left;
    logic           now_left;
    logic [CNT_W+1:0] sum_in;
    logic [CNT_W+1:0] sum_out;
    t = '0;
    n = (lines_used > LINES) ? LINES : int'(lines_used);
    if (hist && int'(id) < TRACKS) begin
      entry = side_map[id];
      for (int l = 0; l < n; l++) begin
        now_left = left_of(line_reg[l], px, py);
        was_left = entry[2*l+1];
        if (entry[2*l]) begin
          if (was_left && !now_left) begin
            out_cnt[l]    = bump(out_cnt[l]);
            t.out_mask[l] = 1'b1;
          end else if (!was_left && now_left) begin
            in_cnt[l]    = bump(in_cnt[l]);
            t.in_mask[l] = 1'b1;
          end
        end
        entry[2*l]   = 1'b1;
        entry[2*l+1] = now_left;
      end
      side_map[id] = entry;
    end
    sum_in  = '0;
    sum_out = '0;
    for (int l = 0; l < n; l++) begin
      sum_in  += in_cnt[l];
      sum_out += out_cnt[l];
    end
    t.total_in  = (sum_in > CNT_FULL) ? CNT_FULL : sum_in[CNT_W-1:0];
    t.total_out = (sum_out > CNT_FULL) ? CNT_FULL : sum_out[CNT_W-1:0];
    t.net       = {1'b0, t.total_in} - {1'b0, t.total_out};
    return t;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0t ns  %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    tally_t want;
    if (!rst_n) begin
      foreach (line_reg[i]) line_reg[i] = '0;
      foreach (side_map[i]) side_map[i] = '0;
      foreach (in_cnt[i]) begin
        in_cnt[i]  = '0;
        out_cnt[i] = '0;
      end
      lines_used = '0;
      expected_tallies.delete();
    end else begin
      // results first: nothing accepted on this edge can already be answered
      if (out_valid && !out_stall) begin
        if (expected_tallies.size() == 0) begin
          flag_mismatch("result with nothing expected, total_in", out_total_in, '0);
        end else begin
          want = expected_tallies.pop_front();
          if (out_total_in !== want.total_in)
            flag_mismatch("total_in", out_total_in, want.total_in);
          if (out_total_out !== want.total_out)
            flag_mismatch("total_out", out_total_out, want.total_out);
          if (out_net_count !== want.net)
            flag_mismatch("net_count", out_net_count, want.net);
          if (out_crossed_in_mask !== want.in_mask)
            flag_mismatch("crossed_in_mask", out_crossed_in_mask, want.in_mask);
          if (out_crossed_out_mask !== want.out_mask)
            flag_mismatch("crossed_out_mask", out_crossed_out_mask, want.out_mask);
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index <= REG_LINE_THREE)
          line_reg[cfg_index[LINE_IDX_W-1:0]] = cfg_data;
        else if (cfg_index == REG_LINES_IN_USE)
          lines_used = cfg_data[LUSE_W-1:0];
      end
      if (in_valid && !in_stall)
        expected_tallies.insert(expected_tallies.size(),
                                tally_update(in_track_id, in_pos_x, in_pos_y,
                                             in_has_history));
    end
    pending_results = expected_tallies.size();
  end

endmodule

FILE: tb/line_crossing_counter_core_tb.sv
`timescale 1ns / 100ps
// Top of the line crossing counter testbench: clock, reset, register writes,
// track update stimulus and the verdict. Depends on lcc_pkg, lcc_crossing_checker.

module line_crossing_counter_core_tb;
  import lcc_pkg::*;

  localparam int CLK_HALF        = 6;     // 12 ns period
  localparam int RESET_CYCLES    = 9;
  localparam int QUIET_LIMIT     = 4000;  // cycles with no transfer on any channel
  localparam int DRAIN_CYCLES    = 20;    // room for a stray result after the last settle
  localparam int BLOCKS_PER_MODE = 3;
  localparam int ITEMS_PER_BLOCK = 58;    // 4 modes x 3 blocks, about 700 updates

  // first register index that maps to nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = REG_LINES_IN_USE + 3'd1;
  localparam logic [POS_W-1:0]     EDGE_HI   = '1;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    logic [ID_W-1:0]  id;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic             hist;
  } update_t;

  // every block input is known from time zero
  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  cfg_valid      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  logic                  in_valid       = 1'b0;
  logic [ID_W-1:0]       in_track_id    = '0;
  logic [POS_W-1:0]      in_pos_x       = '0;
  logic [POS_W-1:0]      in_pos_y       = '0;
  logic                  in_has_history = 1'b0;
  logic                  out_stall      = 1'b0;

  logic                  cfg_ready;
  logic                  in_stall;
  logic                  out_valid;
  logic [CNT_W-1:0]      out_total_in;
  logic [CNT_W-1:0]      out_total_out;
  logic signed [CNT_W:0] out_net_count;
  logic [3:0]            out_crossed_in_mask;
  logic [3:0]            out_crossed_out_mask;

  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int quiet_cycles    = 0;
  int mismatch_count;
  int pending_results;

  // copy of the line registers, used to aim points at endpoints
  logic [CFG_DATA_W-1:0] line_shadow [4] = '{default: '0};

  line_crossing_counter_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_track_id         (in_track_id),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_has_history      (in_has_history),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_total_in        (out_total_in),
    .out_total_out       (out_total_out),
    .out_net_count       (out_net_count),
    .out_crossed_in_mask (out_crossed_in_mask),
    .out_crossed_out_mask(out_crossed_out_mask)
  );

  lcc_crossing_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_track_id         (in_track_id),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_has_history      (in_has_history),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_total_in        (out_total_in),
    .out_total_out       (out_total_out),
    .out_net_count       (out_net_count),
    .out_crossed_in_mask (out_crossed_in_mask),
    .out_crossed_out_mask(out_crossed_out_mask),
    .mismatch_count      (mismatch_count),
    .pending_results     (pending_results)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // receiver back-pressure, redrawn every cycle at the falling edge
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  // watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // register layout: x1 15:0, y1 31:16, x2 47:32, y2 63:48
  function automatic logic [CFG_DATA_W-1:0] seg(input logic [POS_W-1:0] x1,
      input logic [POS_W-1:0] y1, input logic [POS_W-1:0] x2, input logic [POS_W-1:0] y2);
    return {y2, x2, y1, x1};
  endfunction

  function automatic update_t upd(input logic [ID_W-1:0] id, input logic [POS_W-1:0] x,
                                  input logic [POS_W-1:0] y, input logic hist);
    update_t u;
    u.id   = id;
    u.x    = x;
    u.y    = y;
    u.hist = hist;
    return u;
  endfunction

  function automatic logic [POS_W-1:0] edge_coord();
    return $urandom_range(1) ? EDGE_HI : '0;
  endfunction

  // one register write transfer; only called while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx <= REG_LINE_THREE)
      line_shadow[idx[LINE_IDX_W-1:0]] = data;
  endtask

  // valid stays high after the transfer so back-to-back updates need no
  // second assignment in the same step; settle drops it
  task automatic offer_update(input update_t u);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_track_id    <= u.id;
    in_pos_x       <= u.x;
    in_pos_y       <= u.y;
    in_has_history <= u.hist;
    do @(posedge clk); while (in_stall);
  endtask

  // close the input channel and wait until every result has come back
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  // fresh set of lines: mostly arbitrary, some degenerate points, some
  // corner-to-corner spans; random upper bits on the line count register
  task automatic reshape_lines();
    logic [POS_W-1:0]      px;
    logic [POS_W-1:0]      py;
    logic [CFG_DATA_W-1:0] word;
    int                    r;
    logic [LUSE_W-1:0]     count;
    for (int k = 0; k < 4; k++) begin
      if ($urandom_range(4) != 0) begin
        px = POS_W'($urandom);
        py = POS_W'($urandom);
        case ($urandom_range(5))
          0:       word = seg(px, py, px, py);
          1:       word = seg(edge_coord(), edge_coord(), edge_coord(), edge_coord());
          default: word = {$urandom, $urandom};
        endcase
        write_reg(REG_LINE_ZERO + CFG_IDX_W'(k), word);
      end
    end
    if ($urandom_range(3) == 0)
      write_reg(REG_SPARE + CFG_IDX_W'($urandom_range(2)), {$urandom, $urandom});
    r = $urandom_range(19);
    if (r < 2)
      count = '0;
    else if (r < 5)
      count = LUSE_W'(5 + $urandom_range(2));  // beyond the line count, acts as four
    else
      count = LUSE_W'(1 + $urandom_range(3));
    word = {$urandom, $urandom};
    word[LUSE_W-1:0] = count;
    write_reg(REG_LINES_IN_USE, word);
  endtask

  // mostly a small pool of tracks so that each gets seen again and again
  function automatic update_t roam_update();
    update_t          u;
    int               r;
    int               l;
    logic [POS_W-1:0] jx;
    logic [POS_W-1:0] jy;
    r = $urandom_range(9);
    if (r < 8)
      u.id = ID_W'($urandom_range(11));
    else if (r == 8)
      u.id = ID_W'($urandom_range(255));
    else
      u.id = ID_W'(255 - $urandom_range(3));
    u.hist = ($urandom_range(99) < 88);
    r = $urandom_range(19);
    if (r < 3) begin
      u.x = edge_coord();
      u.y = edge_coord();
    end else if (r < 6) begin
      // at or next to an endpoint: cross product zero or tiny
      l  = $urandom_range(3);
      jx = POS_W'($urandom_range(2));
      jy = POS_W'($urandom_range(2));
      if ($urandom_range(1)) begin
        u.x = line_shadow[l][15:0] + jx - 1'b1;
        u.y = line_shadow[l][31:16] + jy - 1'b1;
      end else begin
        u.x = line_shadow[l][47:32] + jx - 1'b1;
        u.y = line_shadow[l][63:48] + jy - 1'b1;
      end
    end else begin
      u.x = POS_W'($urandom);
      u.y = POS_W'($urandom);
    end
    return u;
  endfunction

  initial begin
    idle_mode_t mode;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // counting disabled straight out of reset: all zeros
    offer_update(upd(8'd0, 16'd0, EDGE_HI, 1'b1));
    settle();

    // diagonal, vertical at x=1000, a degenerate point, reversed diagonal
    write_reg(REG_LINE_ZERO, seg(16'd0, 16'd0, EDGE_HI, EDGE_HI));
    write_reg(REG_LINE_ZERO + 3'd1, seg(16'd1000, 16'd0, 16'd1000, EDGE_HI));
    write_reg(REG_LINE_ZERO + 3'd2, seg(16'd0, 16'd0, 16'd0, 16'd0));
    write_reg(REG_LINE_THREE, seg(EDGE_HI, EDGE_HI, 16'd0, 16'd0));
    write_reg(REG_LINES_IN_USE, 64'd4);

    offer_update(upd(8'd0, 16'd0, EDGE_HI, 1'b1));      // first sighting only
    offer_update(upd(8'd0, EDGE_HI, 16'd0, 1'b1));      // out on 0 and 1, in on 3
    offer_update(upd(8'd0, 16'd100, 16'd100, 1'b0));    // no history: ignored
    offer_update(upd(8'd0, 16'd1000, 16'd500, 1'b1));   // exactly on the vertical
    offer_update(upd(8'd0, 16'd500, 16'd500, 1'b1));    // on both diagonals
    offer_update(upd(8'd255, EDGE_HI, EDGE_HI, 1'b1));
    offer_update(upd(8'd255, 16'd0, 16'd0, 1'b1));
    offer_update(upd(8'd128, 16'h5A5A, 16'hA5A5, 1'b0));
    settle();

    // line count above the maximum behaves as four
    write_reg(REG_LINES_IN_USE, {61'h0, 3'd7});
    offer_update(upd(8'd0, 16'd0, EDGE_HI, 1'b1));
    offer_update(upd(8'd0, EDGE_HI, 16'd0, 1'b1));
    settle();

    // one line only: the others keep their history but are left out
    write_reg(REG_LINES_IN_USE, 64'd1);
    offer_update(upd(8'd0, 16'd0, EDGE_HI, 1'b1));
    offer_update(upd(8'd0, EDGE_HI, 16'd0, 1'b1));
    settle();

    // unmapped indexes are dropped; rewriting a line keeps the side table
    write_reg(REG_SPARE, {$urandom, $urandom});
    write_reg(REG_SPARE + 3'd1, '1);
    write_reg(REG_SPARE + 3'd2, {$urandom, $urandom});
    write_reg(REG_LINE_ZERO, seg(EDGE_HI, 16'd0, 16'd0, EDGE_HI));
    write_reg(REG_LINES_IN_USE, 64'd4);
    offer_update(upd(8'd0, 16'd0, EDGE_HI, 1'b1));
    offer_update(upd(8'd0, 16'd0, 16'd0, 1'b1));
    offer_update(upd(8'd255, EDGE_HI, EDGE_HI, 1'b1));
    settle();

    // disabled again: totals read as zero even though counters hold values
    write_reg(REG_LINES_IN_USE, 64'd0);
    offer_update(upd(8'd0, EDGE_HI, 16'd0, 1'b1));
    offer_update(upd(8'd255, 16'd0, EDGE_HI, 1'b1));
    settle();

    // random part, one block of updates per line setting
    for (int k = 0; k < 4; k++) begin
      mode = idle_mode_t'(k);
      case (mode)
        IDLE_NONE:     begin sender_idle_pct = 0;  stall_pct = 0;  end
        IDLE_SENDER:   begin sender_idle_pct = 48; stall_pct = 0;  end
        IDLE_RECEIVER: begin sender_idle_pct = 0;  stall_pct = 48; end
        default:       begin sender_idle_pct = 31; stall_pct = 31; end
      endcase
      for (int b = 0; b < BLOCKS_PER_MODE; b++) begin
        reshape_lines();
        repeat (ITEMS_PER_BLOCK) offer_update(roam_update());
        settle();
      end
    end

    // leave room for any stray result to show up before the verdict
    sender_idle_pct = 0;
    stall_pct       = 0;
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && pending_results == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
